// File: design/adv_pkg.sv
// Shared types and constants of the adaptive voter step block.
// No dependencies; used by adv_decide and adaptive_voter_model_step_top.
package adv_pkg;

    localparam int VOTER_W = 9;
    localparam int DRAW_W  = 16;
    localparam int PROB_W  = 16;
    localparam int LIMIT_W = 21;
    localparam int ONES_W  = 10;
    localparam int VOTE_W  = 32;
    localparam int DEL_W   = 17;
    localparam int IDLE_W  = 21;
    localparam int CFG_W   = 21;

    localparam logic [PROB_W-1:0]  PROB_RESET  = 16'd19661;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 21'd2000000;
    localparam logic [DEL_W-1:0]   DEL_MAX     = '1;
    localparam logic [IDLE_W-1:0]  IDLE_MAX    = '1;

    // Configuration register indexes.
    localparam logic REG_VOTER_PROB = 1'b0;
    localparam logic REG_IDLE_LIMIT = 1'b1;

    typedef enum logic [2:0] {
        OUT_SAME    = 3'd0,
        OUT_NO_EDGE = 3'd1,
        OUT_VOTE    = 3'd2,
        OUT_DELETE  = 3'd3,
        OUT_IGNORED = 3'd4
    } t_outcome;

    // What one sample does to the stored state.
    typedef struct packed {
        t_outcome outcome;
        logic     vote_move;
        logic     edge_delete;
        logic     productive;
    } t_decision;

endpackage

// File: design/adv_ram.sv
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered. No package dependencies.
module adv_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/adv_decide.sv
// Sample decision: classifies one sample from the opinions and edge row read
// out of memory. Depends on adv_pkg for the outcome codes and decision struct.
module adv_decide #(
    parameter int VOTERS = 512
) (
    input  logic [adv_pkg::VOTER_W-1:0] i_first_voter,
    input  logic [adv_pkg::VOTER_W-1:0] i_second_voter,
    input  logic [adv_pkg::DRAW_W-1:0]  i_move_draw,
    input  logic [adv_pkg::PROB_W-1:0]  i_voter_prob,
    input  logic                        i_finished,
    input  logic                        i_opin_a,
    input  logic                        i_opin_b,
    input  logic [VOTERS-1:0]           i_edge_row,
    input  logic [$clog2(VOTERS)-1:0]   i_col,
    output adv_pkg::t_decision          o_dec
);

    logic out_range;

    // An index beyond the voter count behaves as a missing edge.
    assign out_range = (32'(i_first_voter) >= 32'(VOTERS)) ||
                       (32'(i_second_voter) >= 32'(VOTERS));

    always_comb begin
        o_dec = '{outcome: adv_pkg::OUT_SAME, vote_move: 1'b0,
                  edge_delete: 1'b0, productive: 1'b0};
        if (i_finished) begin
            o_dec.outcome = adv_pkg::OUT_IGNORED;
        end else if (out_range) begin
            o_dec.outcome = adv_pkg::OUT_NO_EDGE;
        end else if (i_opin_a == i_opin_b) begin
            o_dec.outcome = adv_pkg::OUT_SAME;
        end else if (!i_edge_row[i_col]) begin
            o_dec.outcome = adv_pkg::OUT_NO_EDGE;
        end else if (i_move_draw < i_voter_prob) begin
            o_dec.outcome    = adv_pkg::OUT_VOTE;
            o_dec.vote_move  = 1'b1;
            o_dec.productive = 1'b1;
        end else begin
            o_dec.outcome     = adv_pkg::OUT_DELETE;
            o_dec.edge_delete = 1'b1;
            o_dec.productive  = 1'b1;
        end
    end

endmodule

// File: design/adaptive_voter_model_step_top.sv
// Top level of the adaptive voter model step block with edge deletion.
// Depends on adv_pkg, adv_ram (opinion and edge stores) and adv_decide.
//
//  channel   direction  handshake                     payload
//  -------   ---------  ----------------------------  ----------------------------------
//  in        to block   i_in_valid / o_in_stall       first_voter, second_voter, move_draw
//  out       from block o_out_valid / i_out_stall     outcome, ones_count, vote_moves,
//                                                     edge_deletions, idle_run, done_res
//  cfg       to block   i_cfg_we (no back pressure)   i_cfg_index, i_cfg_data
//
// Each word is read in S_IDLE, which issues the reads of both opinions and the
// edge row to the synchronous RAMs, and finished in S_EXEC, which decides,
// writes back and loads the output register. The registered RAM read sets this split.
// After reset the block sweeps the RAMs to their start contents (complete
// graph, first half of the voters at opinion one) and stalls the input
// meanwhile. A stalled output holds the execute stage; a new word is taken
// while the previous result still waits in the output register.
//
// The graph is symmetric, so only one bit per voter pair is kept: row
// min(a,b), column max(a,b). Deleting an edge therefore clears a single bit.
// A word is accepted only in the idle state and written back before the state
// machine returns there, so the read of the next word always sees the update
// and no forwarding path is needed.
module adaptive_voter_model_step_top #(
    parameter int VOTERS = 512
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Sample input channel.
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [adv_pkg::VOTER_W-1:0] i_first_voter,
    input  logic [adv_pkg::VOTER_W-1:0] i_second_voter,
    input  logic [adv_pkg::DRAW_W-1:0]  i_move_draw,
    // Result channel.
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [2:0]                  o_outcome,
    output logic [adv_pkg::ONES_W-1:0]  o_ones_count,
    output logic [adv_pkg::VOTE_W-1:0]  o_vote_moves,
    output logic [adv_pkg::DEL_W-1:0]   o_edge_deletions,
    output logic [adv_pkg::IDLE_W-1:0]  o_idle_run,
    output logic                        o_done_res,
    // Configuration write port.
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [adv_pkg::CFG_W-1:0]   i_cfg_data
);

    localparam int AW   = $clog2(VOTERS);
    localparam int CW   = $clog2(VOTERS + 1);
    localparam int HALF = VOTERS / 2;

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_EXEC} t_state;

    t_state                        r_state;
    logic [AW-1:0]                 r_clr_addr;
    logic [adv_pkg::VOTER_W-1:0]   r_first;
    logic [adv_pkg::VOTER_W-1:0]   r_second;
    logic [adv_pkg::DRAW_W-1:0]    r_draw;
    logic [adv_pkg::PROB_W-1:0]    r_voter_prob;
    logic [adv_pkg::LIMIT_W-1:0]   r_idle_limit;
    logic [CW-1:0]                 r_ones;
    logic [adv_pkg::VOTE_W-1:0]    r_vote;
    logic [adv_pkg::DEL_W-1:0]     r_del;
    logic [adv_pkg::IDLE_W-1:0]    r_idle;
    logic                          r_finished;
    logic                          r_out_valid;
    adv_pkg::t_outcome             r_outcome;
    logic [adv_pkg::ONES_W-1:0]    r_out_ones;
    logic [adv_pkg::VOTE_W-1:0]    r_out_vote;
    logic [adv_pkg::DEL_W-1:0]     r_out_del;
    logic [adv_pkg::IDLE_W-1:0]    r_out_idle;
    logic                          r_out_done;

    logic [CW-1:0]                 n_ones;
    logic [adv_pkg::VOTE_W-1:0]    n_vote;
    logic [adv_pkg::DEL_W-1:0]     n_del;
    logic [adv_pkg::IDLE_W-1:0]    n_idle;
    logic                          n_finished;

    logic                          in_accept;
    logic                          exec_fire;
    logic                          clearing;
    logic [AW-1:0]                 sel_a;
    logic [AW-1:0]                 sel_b;
    logic [AW-1:0]                 row_addr;
    logic [AW-1:0]                 col;
    logic [0:0]                    opin_a_q;
    logic [0:0]                    opin_b_q;
    logic [VOTERS-1:0]             edge_row;
    logic [VOTERS-1:0]             col_mask;
    logic                          opin_we;
    logic [AW-1:0]                 opin_waddr;
    logic [0:0]                    opin_wdata;
    logic                          edge_we;
    logic [AW-1:0]                 edge_waddr;
    logic [VOTERS-1:0]             edge_wdata;
    adv_pkg::t_decision            dec;

    assign clearing   = (r_state == S_CLEAR);
    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = (r_state == S_IDLE) && i_in_valid;
    // The execute step finishes once the output register can take the result.
    assign exec_fire  = (r_state == S_EXEC) && (!r_out_valid || !i_out_stall);

    // Read addresses come from the port on acceptance and from the held word
    // afterwards, so the registered read data stays valid during an output stall.
    assign sel_a    = (r_state == S_IDLE) ? AW'(i_first_voter)  : AW'(r_first);
    assign sel_b    = (r_state == S_IDLE) ? AW'(i_second_voter) : AW'(r_second);
    assign row_addr = (sel_a < sel_b) ? sel_a : sel_b;
    assign col      = (sel_a < sel_b) ? sel_b : sel_a;
    assign col_mask = {{(VOTERS - 1){1'b0}}, 1'b1} << col;

    adv_decide #(
        .VOTERS (VOTERS)
    ) u_decide (
        .i_first_voter  (r_first),
        .i_second_voter (r_second),
        .i_move_draw    (r_draw),
        .i_voter_prob   (r_voter_prob),
        .i_finished     (r_finished),
        .i_opin_a       (opin_a_q[0]),
        .i_opin_b       (opin_b_q[0]),
        .i_edge_row     (edge_row),
        .i_col          (col),
        .o_dec          (dec)
    );

    // Write-back: the reset sweep or the update of the executing word.
    assign opin_we    = clearing || (exec_fire && dec.vote_move);
    assign opin_waddr = clearing ? r_clr_addr : AW'(r_second);
    assign opin_wdata = clearing ? (r_clr_addr < AW'(HALF)) : opin_a_q;
    assign edge_we    = clearing || (exec_fire && dec.edge_delete);
    assign edge_waddr = clearing ? r_clr_addr : row_addr;
    assign edge_wdata = clearing ? '1 : (edge_row & ~col_mask);

    // Two copies of the opinion store give one read port per chosen voter.
    adv_ram #(
        .WIDTH (1),
        .DEPTH (VOTERS)
    ) u_opin_a_ram (
        .i_clk   (i_clk),
        .i_we    (opin_we),
        .i_waddr (opin_waddr),
        .i_wdata (opin_wdata),
        .i_raddr (sel_a),
        .o_rdata (opin_a_q)
    );

    adv_ram #(
        .WIDTH (1),
        .DEPTH (VOTERS)
    ) u_opin_b_ram (
        .i_clk   (i_clk),
        .i_we    (opin_we),
        .i_waddr (opin_waddr),
        .i_wdata (opin_wdata),
        .i_raddr (sel_b),
        .o_rdata (opin_b_q)
    );

    adv_ram #(
        .WIDTH (VOTERS),
        .DEPTH (VOTERS)
    ) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (edge_we),
        .i_waddr (edge_waddr),
        .i_wdata (edge_wdata),
        .i_raddr (row_addr),
        .o_rdata (edge_row)
    );

    // Totals after the executing word. Once finished, the decision flags are
    // all clear, so every total holds.
    always_comb begin
        n_ones = r_ones;
        if (dec.vote_move) begin
            n_ones = opin_a_q[0] ? (r_ones + CW'(1)) : (r_ones - CW'(1));
        end
        n_vote = (dec.vote_move && (r_vote != '1)) ?
                 (r_vote + adv_pkg::VOTE_W'(1)) : r_vote;
        n_del  = (dec.edge_delete && (r_del != adv_pkg::DEL_MAX)) ?
                 (r_del + adv_pkg::DEL_W'(1)) : r_del;
        if (r_finished) begin
            n_idle = r_idle;
        end else if (dec.productive) begin
            n_idle = '0;
        end else if (r_idle != adv_pkg::IDLE_MAX) begin
            n_idle = r_idle + adv_pkg::IDLE_W'(1);
        end else begin
            n_idle = r_idle;
        end
        n_finished = r_finished || (n_ones == '0) || (n_ones == CW'(VOTERS)) ||
                     (n_idle >= r_idle_limit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_voter_prob <= adv_pkg::PROB_RESET;
            r_idle_limit <= adv_pkg::LIMIT_RESET;
            r_ones       <= CW'(HALF);
            r_vote       <= '0;
            r_del        <= '0;
            r_idle       <= '0;
            r_finished   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    adv_pkg::REG_VOTER_PROB: begin
                        r_voter_prob <= i_cfg_data[adv_pkg::PROB_W-1:0];
                    end
                    adv_pkg::REG_IDLE_LIMIT: begin
                        r_idle_limit <= i_cfg_data[adv_pkg::LIMIT_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end

            // A new result may replace one that leaves at the same edge.
            if (exec_fire) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == AW'(VOTERS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_accept) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (exec_fire) begin
                        r_state     <= S_IDLE;
                        r_ones      <= n_ones;
                        r_vote      <= n_vote;
                        r_del       <= n_del;
                        r_idle      <= n_idle;
                        r_finished  <= n_finished;
                    end
                end
                default: begin
                    r_state <= S_CLEAR;
                end
            endcase
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_first  <= i_first_voter;
            r_second <= i_second_voter;
            r_draw   <= i_move_draw;
        end
        if (exec_fire) begin
            r_outcome  <= dec.outcome;
            r_out_ones <= adv_pkg::ONES_W'(n_ones);
            r_out_vote <= n_vote;
            r_out_del  <= n_del;
            r_out_idle <= n_idle;
            r_out_done <= n_finished;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_outcome        = r_outcome;
    assign o_ones_count     = r_out_ones;
    assign o_vote_moves     = r_out_vote;
    assign o_edge_deletions = r_out_del;
    assign o_idle_run       = r_out_idle;
    assign o_done_res       = r_out_done;

    // The count of voters at opinion one can never leave its range.
    a_ones_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ones <= CW'(VOTERS))
        else $error("ones count exceeds the number of voters");

    // Once finished, the totals are frozen.
    a_frozen_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_finished |=> $stable(r_vote) && $stable(r_del) && $stable(r_ones))
        else $error("totals changed after the run finished");

    // An ignored word is only reported by a block that is done.
    a_ignored_means_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_outcome == adv_pkg::OUT_IGNORED)) |-> r_out_done)
        else $error("ignored outcome without done");

    // No write may land while a word is being read, or the read would be stale.
    a_no_write_in_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!opin_we && !edge_we))
        else $error("memory write while idle");

endmodule
